>>> hw/rtl/program_file_header_checker_defines.svh
// Assertion macros for the program file header checker
`ifndef PROGRAM_FILE_HEADER_CHECKER_DEFINES_SVH
`define PROGRAM_FILE_HEADER_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define PFHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define PFHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pfhc_pkg.sv
package pfhc_pkg;

  localparam int unsigned NameBytes    = 128;
  localparam int unsigned CommentBytes = 2048;
  localparam int unsigned HeaderBytes  = 2192;

  localparam int unsigned CountW = 20;

  localparam logic [CountW-1:0] NAME_START    = CountW'(4);
  localparam logic [CountW-1:0] PAD1_START    = CountW'(4 + NameBytes);
  localparam logic [CountW-1:0] SIZE_START    = CountW'(8 + NameBytes);
  localparam logic [CountW-1:0] COMMENT_START = CountW'(12 + NameBytes);
  localparam logic [CountW-1:0] PAD2_START    = CountW'(12 + NameBytes + CommentBytes);
  localparam logic [CountW-1:0] HEADER_START  = CountW'(HeaderBytes);
  localparam logic [CountW-1:0] COUNT_MAX     = {CountW{1'b1}};
  localparam logic [CountW-1:0] MAGIC_LAST    = CountW'(3);
  localparam logic [CountW-1:0] SIZE_LAST     = CountW'(11 + NameBytes);

  localparam logic [31:0] MAGIC_RESET    = 32'd15369203;
  localparam logic [15:0] MAX_CODE_RESET = 16'd682;

  typedef enum logic [0:0] {
    CFG_EXPECTED_MAGIC = 1'b0,
    CFG_MAX_CODE_BYTES = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SEC_MAGIC   = 3'd0,
    SEC_NAME    = 3'd1,
    SEC_PAD1    = 3'd2,
    SEC_SIZE    = 3'd3,
    SEC_COMMENT = 3'd4,
    SEC_PAD2    = 3'd5,
    SEC_CODE    = 3'd6,
    SEC_END     = 3'd7
  } section_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_MAGIC    = 3'd1,
    ST_BAD_SIZE     = 3'd2,
    ST_CODE_LONG    = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_TOO_SHORT    = 3'd5
  } status_t;

  typedef struct packed {
    section_t    section;
    logic [15:0] section_offset;
    logic [7:0]  byte_out;
    status_t     status;
    logic [15:0] declared_code_bytes;
  } result_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

>>> hw/rtl/pfhc_in_if.sv
interface pfhc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

>>> hw/rtl/pfhc_out_if.sv
interface pfhc_out_if import pfhc_pkg::*; ;
  logic        valid;
  logic        ready;
  section_t    section;
  logic [15:0] section_offset;
  logic [7:0]  byte_out;
  status_t     status;
  logic [15:0] declared_code_bytes;

  modport source (output valid, output section, output section_offset, output byte_out,
                  output status, output declared_code_bytes, input ready);
  modport sink (input valid, input section, input section_offset, input byte_out,
                input status, input declared_code_bytes, output ready);
endinterface

>>> hw/rtl/program_file_header_checker.sv
// Channel  | Direction | Payload
// in_if    | sink      | kind, data_byte
// out_if   | source    | section, section_offset, byte_out, status, declared_code_bytes
// cfg_*    | write     | cfg_we, cfg_index, cfg_wdata
//
// One item per cycle while in_if.ready is high; each result is registered after
// the tag/check logic, in the result register or the skid register if out_if stalls.
// A two-entry output (result register plus skid register) keeps in_if.ready
// registered; an item is still taken while one result waits on out_if.
// Synchronous active-low reset clears counters, error and holds reset register values.
`include "program_file_header_checker_defines.svh"

module program_file_header_checker import pfhc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  pfhc_in_if.sink       in_if,
  pfhc_out_if.source    out_if,
  input  logic          cfg_we,
  input  cfg_idx_t      cfg_index,
  input  logic [31:0]   cfg_wdata
);

  logic [31:0]       magic_r;
  logic [15:0]       max_code_r;
  logic [CountW-1:0] count_r, count_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [15:0]       code_size_r, code_size_nxt;
  status_t           sticky_r, sticky_nxt;

  result_t           out_r, skid_r, res;
  logic              out_valid_r, skid_valid_r;

  logic              accept, out_fire, raise;
  status_t           raise_code;
  section_t          sec;
  logic [CountW-1:0] off;

  assign accept   = in_if.valid && in_if.ready;
  assign out_fire = out_valid_r && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= MAGIC_RESET;
      max_code_r <= MAX_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_MAGIC: magic_r    <= cfg_wdata;
        CFG_MAX_CODE_BYTES: max_code_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    word_nxt      = word_r;
    count_nxt     = count_r;
    code_size_nxt = code_size_r;
    raise         = 1'b0;
    raise_code    = ST_OK;
    sec           = SEC_END;
    off           = count_r;
    if (in_if.kind) begin
      if (code_size_r != 16'd0) begin
        if (count_r < HEADER_START ||
            (count_r - HEADER_START) != {{(CountW-16){1'b0}}, code_size_r}) begin
          raise      = 1'b1;
          raise_code = ST_LEN_MISMATCH;
        end
      end else if (count_r < HEADER_START) begin
        raise      = 1'b1;
        raise_code = ST_TOO_SHORT;
      end
    end else begin
      word_nxt = {word_r[23:0], in_if.data_byte};
      priority if (count_r < NAME_START) begin
        sec = SEC_MAGIC;
        off = count_r;
        if (count_r == MAGIC_LAST && word_nxt != magic_r) begin
          raise      = 1'b1;
          raise_code = ST_BAD_MAGIC;
        end
      end else if (count_r < PAD1_START) begin
        sec = SEC_NAME;
        off = count_r - NAME_START;
      end else if (count_r < SIZE_START) begin
        sec = SEC_PAD1;
        off = count_r - PAD1_START;
      end else if (count_r < COMMENT_START) begin
        sec = SEC_SIZE;
        off = count_r - SIZE_START;
        if (count_r == SIZE_LAST) begin
          if (word_nxt[31]) begin
            code_size_nxt = 16'd0;
            raise         = 1'b1;
            raise_code    = ST_BAD_SIZE;
          end else begin
            code_size_nxt = sat16(word_nxt);
            if (word_nxt > {16'd0, max_code_r}) begin
              raise      = 1'b1;
              raise_code = ST_BAD_SIZE;
            end
          end
        end
      end else if (count_r >= HEADER_START) begin
        sec = SEC_CODE;
        off = count_r - HEADER_START;
        if (off >= {{(CountW-16){1'b0}}, code_size_r}) begin
          raise      = 1'b1;
          raise_code = ST_CODE_LONG;
        end
      end else if (count_r < PAD2_START) begin
        sec = SEC_COMMENT;
        off = count_r - COMMENT_START;
      end else begin
        sec = SEC_PAD2;
        off = count_r - PAD2_START;
      end
      if (count_r < COUNT_MAX) begin
        count_nxt = count_r + CountW'(1);
      end
    end
    sticky_nxt = (sticky_r == ST_OK && raise) ? raise_code : sticky_r;

    res.section             = sec;
    res.section_offset      = sat16({{(32-CountW){1'b0}}, off});
    res.byte_out            = in_if.kind ? 8'd0 : in_if.data_byte;
    res.status              = sticky_nxt;
    res.declared_code_bytes = code_size_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      word_r      <= '0;
      code_size_r <= '0;
      sticky_r    <= ST_OK;
    end else if (accept) begin
      count_r     <= count_nxt;
      word_r      <= word_nxt;
      code_size_r <= code_size_nxt;
      sticky_r    <= sticky_nxt;
    end
  end

  // hold a result in the skid register while the output register is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign in_if.ready                = !skid_valid_r;
  assign out_if.valid               = out_valid_r;
  assign out_if.section             = out_r.section;
  assign out_if.section_offset      = out_r.section_offset;
  assign out_if.byte_out            = out_r.byte_out;
  assign out_if.status              = out_r.status;
  assign out_if.declared_code_bytes = out_r.declared_code_bytes;

  `PFHC_ASSERT_NEXT(a_sticky_holds, sticky_r != ST_OK, sticky_r == $past(sticky_r),
                    "sticky error changed")
  `PFHC_ASSERT_NOW(a_skid_needs_out, skid_valid_r, out_valid_r,
                   "skid register full while output register empty")
  `PFHC_ASSERT_NOW(a_size_after_header, code_size_r != 16'd0, count_r >= COMMENT_START,
                   "code size set before size field was read")

endmodule
